[rtl/core/pwfr_pkg.sv]
// pwfr_pkg: shared types and constants of the pulse-width frame receiver
// used by every module under rtl/core; depends on nothing
`default_nettype none

package pwfr_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [3:0] ADDR_SAMPLE_DELAY   = 4'h0;
	localparam logic [3:0] ADDR_ONE_HOLD       = 4'h4;
	localparam logic [3:0] ADDR_WAIT_LIMIT     = 4'h8;
	localparam logic [3:0] ADDR_FRAME_CAPACITY = 4'hC;

	localparam logic [7:0] RST_SAMPLE_DELAY   = 8'd5;
	localparam logic [7:0] RST_ONE_HOLD       = 8'd10;
	localparam logic [7:0] RST_WAIT_LIMIT     = 8'd254;
	localparam logic [7:0] RST_FRAME_CAPACITY = 8'd16;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// one classified line sample
	typedef struct packed {
		logic line;
		logic fall;
	} item_t;

	typedef struct packed {
		logic [7:0] sample_delay;
		logic [7:0] one_hold;
		logic [7:0] wait_limit;
		logic [7:0] frame_capacity;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

[rtl/core/pwfr_front.sv]
// pwfr_front: accepts line samples and marks falling edges
// depends on pwfr_pkg
`default_nettype none

module pwfr_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire              line_level,
	input  pwfr_pkg::qstat_t qstat,
	output logic             push,
	output pwfr_pkg::item_t  push_item
);

	logic last_q;

	assign in_ready       = ~qstat.full;
	assign push           = in_valid & ~qstat.full;
	assign push_item.line = line_level;
	assign push_item.fall = last_q & ~line_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (push) begin
			last_q <= line_level;
		end
	end

endmodule

`default_nettype wire

[rtl/core/pwfr_queue.sv]
// pwfr_queue: short register queue between front and back
// depends on pwfr_pkg
`default_nettype none

module pwfr_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  pwfr_pkg::item_t  push_item,
	input  wire              pop,
	output pwfr_pkg::item_t  head,
	output pwfr_pkg::qstat_t qstat
);

	pwfr_pkg::item_t                  mem_q [pwfr_pkg::QDEPTH];
	logic [pwfr_pkg::QPTR_W-1:0] wr_q;
	logic [pwfr_pkg::QPTR_W-1:0] rd_q;
	logic [pwfr_pkg::QCNT_W-1:0] cnt_q;

	assign head        = mem_q[rd_q];
	assign qstat.full  = (cnt_q == pwfr_pkg::QCNT_W'(pwfr_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/pwfr_back.sv]
// pwfr_back: frame decoder state machine and output register
// depends on pwfr_pkg
`default_nettype none

module pwfr_back (
	input  wire              clk,
	input  wire              arst_n,
	input  pwfr_pkg::cfg_t   cfg,
	input  pwfr_pkg::item_t  head,
	input  pwfr_pkg::qstat_t qstat,
	output logic             pop,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [7:0]       data_byte,
	output logic [7:0]       byte_index,
	output logic             frame_last,
	output logic             empty_frame
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAITLOW,
		PH_DELAY,
		PH_HOLD,
		PH_TAIL,
		PH_HOLDEND
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] tick_q, tick_d;
	logic [3:0] bits_q, bits_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] nbytes_q, nbytes_d;
	logic [7:0] tick_inc;
	logic [8:0] nbytes_inc;
	logic       emit;
	logic       last;
	logic [7:0] res_byte;
	logic [7:0] res_index;
	logic       res_last;
	logic       res_empty;
	logic       out_valid_q;

	assign pop        = ~qstat.empty & (~out_valid_q | out_ready);
	assign out_valid  = out_valid_q;
	assign tick_inc   = tick_q + 8'd1;
	assign nbytes_inc = {1'b0, nbytes_q} + 9'd1;
	assign last       = head.line | (nbytes_inc >= {1'b0, cfg.frame_capacity});

	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		bits_d    = bits_q;
		shift_d   = shift_q;
		nbytes_d  = nbytes_q;
		emit      = 1'b0;
		res_byte  = shift_q;
		res_index = nbytes_q;
		res_last  = 1'b0;
		res_empty = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (head.fall) begin
					bits_d   = '0;
					shift_d  = '0;
					nbytes_d = '0;
					tick_d   = '0;
					if (cfg.frame_capacity == 8'd0) begin
						emit      = 1'b1;
						res_byte  = '0;
						res_index = '0;
						res_last  = 1'b1;
						res_empty = 1'b1;
						phase_d   = PH_TAIL;
					end else begin
						phase_d = PH_WAITLOW;
					end
				end
			end
			PH_WAITLOW, PH_TAIL: begin
				if (head.line || tick_inc >= cfg.wait_limit) begin
					tick_d  = '0;
					phase_d = (phase_q == PH_WAITLOW) ? PH_DELAY : PH_IDLE;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_DELAY: begin
				tick_d = tick_inc;
				if (tick_inc >= cfg.sample_delay) begin
					tick_d = '0;
					if (bits_q < pwfr_pkg::BITS_PER_BYTE) begin
						shift_d = {shift_q[6:0], head.line};
						bits_d  = bits_q + 4'd1;
					end else begin
						emit     = 1'b1;
						res_last = last;
						bits_d   = '0;
						shift_d  = '0;
						nbytes_d = last ? 8'd0 : nbytes_inc[7:0];
					end
					if (head.line && cfg.one_hold != 8'd0) begin
						phase_d = (emit && last) ? PH_HOLDEND : PH_HOLD;
					end else begin
						phase_d = (emit && last) ? PH_TAIL : PH_WAITLOW;
					end
				end
			end
			PH_HOLD, PH_HOLDEND: begin
				tick_d = tick_inc;
				if (tick_inc >= cfg.one_hold) begin
					tick_d  = '0;
					phase_d = (phase_q == PH_HOLD) ? PH_WAITLOW : PH_TAIL;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				tick_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bits_q      <= '0;
			shift_q     <= '0;
			nbytes_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				phase_q  <= phase_d;
				tick_q   <= tick_d;
				bits_q   <= bits_d;
				shift_q  <= shift_d;
				nbytes_q <= nbytes_d;
				if (emit) begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			data_byte   <= res_byte;
			byte_index  <= res_index;
			frame_last  <= res_last;
			empty_frame <= res_empty;
		end
	end

endmodule

`default_nettype wire

[rtl/core/pulse_width_frame_receiver.sv]
// pulse_width_frame_receiver: top level with register file
// depends on pwfr_pkg, pwfr_front, pwfr_queue, pwfr_back
//
// usage: one line sample is taken per word on the input channel (in_valid,
// in_ready, line_level), normally one per oversampling tick. the front
// marks falling edges and writes each sample into a two-entry queue; the
// back runs the frame state machine, one queued sample per cycle, and loads
// a result word into the output register (out_valid, out_ready, data_byte,
// byte_index, frame_last, empty_frame) when a byte completes at its end
// mark fragment, or at once for an empty frame when frame_capacity is zero.
// throughput: one sample per cycle while the output side keeps up; a byte's
// last sample is queued, then a state machine step loads its result word
// into the output register. when a result word waits unaccepted the back
// stops and the queue fills; in_ready falls once both queue entries are
// taken. reset clears the state machine, the queue and the output valid,
// and loads the registers with sample_delay 5, one_hold 10, wait_limit
// 254, frame_capacity 16. registers are written over the apb port; the
// user must write them only while idle; the block does not enforce it.
`default_nettype none

module pulse_width_frame_receiver (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         line_level,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  data_byte,
	output logic [7:0]  byte_index,
	output logic        frame_last,
	output logic        empty_frame
);

	pwfr_pkg::cfg_t   cfg_q;
	pwfr_pkg::item_t  push_item;
	pwfr_pkg::item_t  head;
	pwfr_pkg::qstat_t qstat;
	logic             push;
	logic             pop;
	logic             wr_en;
	logic [3:0]       reg_addr;

	assign pready   = 1'b1;
	assign wr_en    = psel & penable & pwrite;
	assign reg_addr = {paddr[3:2], 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_delay   <= pwfr_pkg::RST_SAMPLE_DELAY;
			cfg_q.one_hold       <= pwfr_pkg::RST_ONE_HOLD;
			cfg_q.wait_limit     <= pwfr_pkg::RST_WAIT_LIMIT;
			cfg_q.frame_capacity <= pwfr_pkg::RST_FRAME_CAPACITY;
		end else if (wr_en) begin
			case (reg_addr)
				pwfr_pkg::ADDR_SAMPLE_DELAY: begin
					cfg_q.sample_delay <= pwdata[7:0];
				end
				pwfr_pkg::ADDR_ONE_HOLD: begin
					cfg_q.one_hold <= pwdata[7:0];
				end
				pwfr_pkg::ADDR_WAIT_LIMIT: begin
					cfg_q.wait_limit <= pwdata[7:0];
				end
				pwfr_pkg::ADDR_FRAME_CAPACITY: begin
					cfg_q.frame_capacity <= pwdata[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_addr)
			pwfr_pkg::ADDR_SAMPLE_DELAY:   prdata = {24'd0, cfg_q.sample_delay};
			pwfr_pkg::ADDR_ONE_HOLD:       prdata = {24'd0, cfg_q.one_hold};
			pwfr_pkg::ADDR_WAIT_LIMIT:     prdata = {24'd0, cfg_q.wait_limit};
			pwfr_pkg::ADDR_FRAME_CAPACITY: prdata = {24'd0, cfg_q.frame_capacity};
			default:                       prdata = '0;
		endcase
	end

	pwfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.line_level (line_level),
		.qstat      (qstat),
		.push       (push),
		.push_item  (push_item)
	);

	pwfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	pwfr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.data_byte   (data_byte),
		.byte_index  (byte_index),
		.frame_last  (frame_last),
		.empty_frame (empty_frame)
	);

endmodule

`default_nettype wire
